// File: hw/rtl/lfuc_pkg.sv
// Shared types and constants for the LFU cache with recency tie breaking.
// Holds the request/response payload structs, the controller state encoding
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package lfuc_pkg;

  // Number of entry rows held in the cache
  localparam int unsigned Depth   = 16;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned FillW   = $clog2(Depth + 1);
  localparam int unsigned CapW    = 5;
  localparam int unsigned CmpW    = (CapW > FillW) ? CapW : FillW;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CntW    = 32;

  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic [CntW-1:0] CntMax   = {CntW{1'b1}};

  // Request type codes
  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
    logic signed [DataW-1:0] evicted_key;
  } rsp_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StLookup = 5'b00010,
    StPick   = 5'b00100,
    StOrder  = 5'b01000,
    StMove   = 5'b10000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic lookup;
    logic pick;
    logic order;
    logic move;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/lfuc_ctrl.sv
// Controller for the LFU cache: one-hot sequencer over lookup, row pick,
// order search and row move. Depends on lfuc_pkg.
`timescale 1ns / 1ps

module lfuc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lfuc_pkg::status_t status_i,
  output lfuc_pkg::cmd_t    cmd_o
);
  import lfuc_pkg::*;

  state_e state_q, state_d;

  // Sequence one request through the datapath
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StLookup;
      StLookup: state_d = StPick;
      StPick:   state_d = StOrder;
      StOrder:  state_d = StMove;
      StMove:   if (status_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands
  assign in_stall_o    = (state_q != StIdle);
  assign cmd_o.accept  = (state_q == StIdle) && in_valid_i;
  assign cmd_o.lookup  = (state_q == StLookup);
  assign cmd_o.pick    = (state_q == StPick);
  assign cmd_o.order   = (state_q == StOrder);
  assign cmd_o.move    = (state_q == StMove);

endmodule

// File: hw/rtl/lfuc_dpath.sv
// Datapath for the LFU cache: entry rows, key match, slot choice, order
// search, row shift and the output register. Depends on lfuc_pkg.
`timescale 1ns / 1ps

module lfuc_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfuc_pkg::CapW-1:0] cfg_wdata_i,
  input  lfuc_pkg::req_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lfuc_pkg::rsp_t            out_data_o,
  input  lfuc_pkg::cmd_t            cmd_i,
  output lfuc_pkg::status_t         status_o
);
  import lfuc_pkg::*;

  // Entry rows, ordered by count then recency
  logic signed [DataW-1:0] key_q [Depth];
  logic signed [DataW-1:0] val_q [Depth];
  logic [CntW-1:0]         cnt_q [Depth];
  logic signed [DataW-1:0] prev_key [Depth];
  logic signed [DataW-1:0] prev_val [Depth];
  logic [CntW-1:0]         prev_cnt [Depth];

  logic [FillW-1:0] filled_q;
  logic [CapW-1:0]  cap_q;
  req_t             req_q;

  // Lookup results
  logic [IdxW-1:0] p_q, p_d;
  logic            hit_q, evict_q, append_q, touch_q;
  logic            evict_d, append_d, touch_d;
  logic [Depth-1:0] match;
  logic             any_hit;
  logic [IdxW-1:0]  hit_idx;
  logic [FillW-1:0] eff_cap;
  logic             full;

  // Touched entry and pending response
  logic signed [DataW-1:0] t_key_q, t_val_q;
  logic [CntW-1:0]         t_cnt_q;
  rsp_t                    rsp_pend_q;
  logic [IdxW-1:0]         q_q, q_d;

  logic out_valid_q;
  rsp_t out_data_q;
  logic out_free;
  logic do_move;

  // Clamp the capacity register to 1..Depth
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = FillW'(1);
    end else if (CmpW'(cap_q) > CmpW'(Depth)) begin
      eff_cap = FillW'(Depth);
    end else begin
      eff_cap = FillW'(cap_q);
    end
  end

  // Match the key against every filled row, take the lowest hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      match[i] = (FillW'(i) < filled_q) && (key_q[i] == req_q.key);
    end
    for (int i = Depth - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IdxW'(i);
    end
    any_hit = |match;
  end

  // Choose the slot to touch
  always_comb begin
    full     = (filled_q >= eff_cap);
    evict_d  = !any_hit && (req_q.req_type == ReqPut) && full;
    append_d = !any_hit && (req_q.req_type == ReqPut) && !full;
    touch_d  = any_hit || (req_q.req_type == ReqPut);
    if (any_hit) begin
      p_d = hit_idx;
    end else if (full) begin
      p_d = IdxW'(eff_cap - FillW'(1));
    end else begin
      p_d = IdxW'(filled_q);
    end
  end

  // Find where the touched entry lands: just behind the last earlier row
  // whose count exceeds its new count
  always_comb begin
    q_d = '0;
    for (int i = 0; i < Depth; i++) begin
      if ((IdxW'(i) < p_q) && (cnt_q[i] > t_cnt_q)) q_d = IdxW'(i + 1);
    end
  end

  // Neighbor taps for the shift
  assign prev_key[0] = key_q[0];
  assign prev_val[0] = val_q[0];
  assign prev_cnt[0] = cnt_q[0];
  for (genvar g = 1; g < Depth; g++) begin : g_tap
    assign prev_key[g] = key_q[g-1];
    assign prev_val[g] = val_q[g-1];
    assign prev_cnt[g] = cnt_q[g-1];
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign do_move  = cmd_i.move && out_free;

  // Control registers: capacity, fill and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.pick && append_q) filled_q <= filled_q + FillW'(1);
      if (do_move) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    // Capture the request on transfer
    if (cmd_i.accept) req_q <= in_data_i;

    if (cmd_i.lookup) begin
      p_q      <= p_d;
      hit_q    <= any_hit;
      evict_q  <= evict_d;
      append_q <= append_d;
      touch_q  <= touch_d;
    end

    // Read the chosen row and form the touched entry and response
    if (cmd_i.pick) begin
      t_key_q <= hit_q ? key_q[p_q] : req_q.key;
      t_val_q <= (req_q.req_type == ReqPut) ? req_q.value : val_q[p_q];
      if (!hit_q) begin
        t_cnt_q <= CntW'(1);
      end else if (cnt_q[p_q] == CntMax) begin
        t_cnt_q <= cnt_q[p_q];
      end else begin
        t_cnt_q <= cnt_q[p_q] + CntW'(1);
      end
      rsp_pend_q.hit         <= hit_q;
      rsp_pend_q.read_value  <= (hit_q && (req_q.req_type == ReqGet)) ? val_q[p_q] : '0;
      rsp_pend_q.evicted     <= evict_q;
      rsp_pend_q.evicted_key <= evict_q ? key_q[p_q] : '0;
    end

    if (cmd_i.order) q_q <= q_d;

    // Shift rows q..p-1 back by one and drop the touched entry at q
    if (do_move && touch_q) begin
      for (int i = 0; i < Depth; i++) begin
        if (IdxW'(i) == q_q) begin
          key_q[i] <= t_key_q;
          val_q[i] <= t_val_q;
          cnt_q[i] <= t_cnt_q;
        end else if ((IdxW'(i) > q_q) && (IdxW'(i) <= p_q)) begin
          key_q[i] <= prev_key[i];
          val_q[i] <= prev_val[i];
          cnt_q[i] <= prev_cnt[i];
        end
      end
    end

    if (do_move) out_data_q <= rsp_pend_q;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.out_free = out_free;

endmodule

// File: hw/rtl/lfu_cache_lru_tiebreak.sv
// Top level of the LFU key-value cache with recency tie breaking.
// Instantiates lfuc_ctrl and lfuc_dpath; depends on lfuc_pkg.
//
// Usage:
//   Requests arrive on in_valid_i / in_stall_o / in_data_i (get or put of a
//   key). Every request yields exactly one response on out_valid_o /
//   out_stall_i / out_data_o: hit flag, read value on a get hit, and the
//   evicted key when a put of a new key replaced an entry.
//   A request transfers while the block is idle; it then passes through
//   lookup, row pick, order search and the row move, which also loads the
//   response into the output register. No new request is taken until the
//   current one leaves its move step: the sequencer handles one at a time
//   because each request reorders the entry rows that the next one searches.
//   The output register lets the block take the next request while a
//   response waits; if the receiver keeps stalling, the next request halts
//   in its move step until the output register frees, so nothing is lost.
//   Reset empties the cache (fill count zero) and sets the capacity
//   register to 16; no clearing pass is needed. cfg_we_i / cfg_wdata_i
//   write the capacity register; write it only while the block is idle.
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfuc_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lfuc_pkg::req_t            in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lfuc_pkg::rsp_t            out_data_o
);
  import lfuc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lfuc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfuc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: tb/lfu_cache_lru_tiebreak_tb.sv
// Self-checking testbench for lfu_cache_lru_tiebreak (LFU cache, recency tie break).
// Depends on lfuc_pkg and the RTL. It runs a directed table, then random phases
// that each begin by writing the capacity register.
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_tb;
  import lfuc_pkg::*;

  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 12;
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned PoolSize     = 24;
  localparam int unsigned Phases       = 10;
  localparam int unsigned PhaseItems   = 153;
  localparam int unsigned QuietPhase   = 4;
  localparam int unsigned GapPct       = 50;
  localparam int unsigned DirRows      = 19;

  localparam logic signed [DataW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] KeyMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] AllOne = -32'sd1;
  localparam logic signed [DataW-1:0] Zero   = 32'sd0;
  localparam logic signed [DataW-1:0] Alt5   = 32'sh5555_5555;
  localparam logic signed [DataW-1:0] AltA   = 32'shaaaa_aaaa;

  localparam rsp_t MissRsp = '0;
  localparam req_t NoReq   = '0;

  typedef enum logic {RowCfg, RowReq} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [CapW-1:0] cap;
    req_t            req;
    logic            typed;
    rsp_t            exp;
  } plan_row_t;

  typedef struct packed {
    logic typed;
    rsp_t rsp;
  } quoted_rsp_t;

  // Directed table: small capacity first so that eviction shows up early
  localparam plan_row_t DirPlan [DirRows] = '{
    '{RowCfg, 5'd2,  NoReq,                    1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqGet, Zero, AllOne},  1'b1, MissRsp},
    '{RowReq, 5'd0,  '{ReqPut, KeyMin, KeyMax}, 1'b1, MissRsp},
    '{RowReq, 5'd0,  '{ReqPut, KeyMax, KeyMin}, 1'b1, MissRsp},
    '{RowReq, 5'd0,  '{ReqGet, KeyMin, Zero},  1'b1, '{1'b1, KeyMax, 1'b0, Zero}},
    '{RowReq, 5'd0,  '{ReqPut, AllOne, Zero},  1'b1, '{1'b0, Zero, 1'b1, KeyMax}},
    '{RowReq, 5'd0,  '{ReqPut, KeyMin, AllOne}, 1'b1, '{1'b1, Zero, 1'b0, Zero}},
    '{RowReq, 5'd0,  '{ReqGet, KeyMin, KeyMax}, 1'b1, '{1'b1, AllOne, 1'b0, Zero}},
    '{RowReq, 5'd0,  '{ReqGet, KeyMax, Zero},  1'b1, MissRsp},
    '{RowReq, 5'd0,  '{ReqPut, Zero, Zero},    1'b1, '{1'b0, Zero, 1'b1, AllOne}},
    // capacity zero acts as one, and the fill now exceeds it
    '{RowCfg, 5'd0,  NoReq,                    1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqPut, 32'sh1234_5678, 32'sd1}, 1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqGet, Zero, Zero},    1'b0, MissRsp},
    // capacity above the row count saturates
    '{RowCfg, 5'd31, NoReq,                    1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqPut, Alt5, AltA},    1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqPut, AltA, Alt5},    1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqGet, Alt5, Zero},    1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqGet, AltA, AllOne},  1'b0, MissRsp},
    '{RowReq, 5'd0,  '{ReqGet, 32'sd1, Zero},  1'b0, MissRsp}
  };

  localparam logic [CapW-1:0] PhaseCap [Phases] = '{
    5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5
  };

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  req_t            in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  rsp_t            out_data_o;

  // Predictor state: entry rows in list order, fill count and capacity
  logic [DataW-1:0] slot_key  [Depth];
  logic [DataW-1:0] slot_val  [Depth];
  logic [CntW-1:0]  slot_uses [Depth];
  int unsigned      fill_cnt = 0;
  logic [CapW-1:0]  cap_reg  = CapReset;

  rsp_t        due_rsp_q  [$];
  quoted_rsp_t plan_rsp_q [$];
  logic [DataW-1:0] key_pool [PoolSize];

  int unsigned fault_cnt   = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_burst = 0;
  logic        quiet_run   = 1'b0;

  lfu_cache_lru_tiebreak dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    fault_cnt++;
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
  endtask

  // Count one use of row start and bubble it ahead of rows with a lower or equal count
  function automatic void count_use(input int unsigned start);
    int unsigned      p;
    logic [DataW-1:0] tk, tv;
    logic [CntW-1:0]  tc;
    p = start;
    if (slot_uses[p] != CntMax) slot_uses[p] = slot_uses[p] + CntW'(1);
    while (p > 0 && slot_uses[p-1] <= slot_uses[p]) begin
      tk = slot_key[p-1];
      tv = slot_val[p-1];
      tc = slot_uses[p-1];
      slot_key[p-1]  = slot_key[p];
      slot_val[p-1]  = slot_val[p];
      slot_uses[p-1] = slot_uses[p];
      slot_key[p]  = tk;
      slot_val[p]  = tv;
      slot_uses[p] = tc;
      p--;
    end
  endfunction

  // Apply one request to the predictor and return the response it owes
  function automatic rsp_t predict_access(input req_t r);
    int unsigned i, pos, lim;
    rsp_t        res;
    res = '0;
    pos = fill_cnt;
    for (i = 0; i < fill_cnt; i++) begin
      if (pos == fill_cnt && slot_key[i] == r.key) pos = i;
    end
    if (pos < fill_cnt) begin
      res.hit = 1'b1;
      if (r.req_type == ReqPut) begin
        slot_val[pos] = r.value;
      end else begin
        res.read_value = slot_val[pos];
      end
      count_use(pos);
    end else if (r.req_type == ReqPut) begin
      lim = (cap_reg == 0) ? 1 : ((int'(cap_reg) > Depth) ? Depth : int'(cap_reg));
      if (fill_cnt >= lim) begin
        // full, or capacity shrunk below the fill: replace the row at lim-1
        pos = lim - 1;
        res.evicted     = 1'b1;
        res.evicted_key = slot_key[pos];
      end else begin
        pos = fill_cnt;
        fill_cnt++;
      end
      slot_key[pos]  = r.key;
      slot_val[pos]  = r.value;
      slot_uses[pos] = '0;
      count_use(pos);
    end
    return res;
  endfunction

  // Drive one request and hold it until the transfer; maybe idle first
  task automatic issue_req(input req_t r, input logic typed, input rsp_t exp);
    int unsigned gap;
    quoted_rsp_t note;
    if (!quiet_run && $urandom_range(0, 99) < GapPct) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    note.typed = typed;
    note.rsp   = exp;
    plan_rsp_q.insert(plan_rsp_q.size(), note);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain all responses, let the block settle, then write the capacity register
  task automatic write_capacity(input logic [CapW-1:0] v);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (due_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
  endtask

  // Stall the response side at random, with occasional long bursts
  always @(posedge clk_i) begin
    if (quiet_run) begin
      stall_burst <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      stall_burst <= $urandom_range(4, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 15);
    end
  end

  // Record request transfers, check response transfers, watch for a hang
  always @(posedge clk_i) begin : scoreboard
    rsp_t        want;
    quoted_rsp_t note;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = predict_access(in_data_i);
        note = plan_rsp_q.pop_front();
        due_rsp_q.insert(due_rsp_q.size(), note.typed ? note.rsp : want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("response with no request pending", out_data_o.evicted_key, '0);
        end else begin
          want = due_rsp_q.pop_front();
          if (out_data_o.hit !== want.hit)
            report_mismatch("hit", 32'(out_data_o.hit), 32'(want.hit));
          if (out_data_o.read_value !== want.read_value)
            report_mismatch("read_value", out_data_o.read_value, want.read_value);
          if (out_data_o.evicted !== want.evicted)
            report_mismatch("evicted", 32'(out_data_o.evicted), 32'(want.evicted));
          if (out_data_o.evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", out_data_o.evicted_key, want.evicted_key);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("lfu_cache_lru_tiebreak regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    req_t            r;
    int unsigned     k, ph, n, sel, eff, hot_n;
    logic [CapW-1:0] cap_v;
    logic [DataW-1:0] extreme_key [4];
    extreme_key = '{KeyMin, KeyMax, AllOne, Zero};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (k = 0; k < DirRows; k++) begin
      if (DirPlan[k].kind == RowCfg) begin
        write_capacity(DirPlan[k].cap);
      end else begin
        issue_req(DirPlan[k].req, DirPlan[k].typed, DirPlan[k].exp);
      end
    end

    // Random phases: keys mostly from a pool that partly survives each phase,
    // so rows left beyond a shrunk capacity still get hit
    for (k = 0; k < PoolSize; k++) key_pool[k] = $urandom;
    for (ph = 0; ph < Phases; ph++) begin
      cap_v = (ph == Phases - 1) ? CapW'($urandom_range(0, 31)) : PhaseCap[ph];
      write_capacity(cap_v);
      quiet_run <= (ph == QuietPhase);
      for (k = 0; k < PoolSize; k++) begin
        if ($urandom_range(0, 99) < 40) key_pool[k] = $urandom;
      end
      eff   = (cap_v == 0) ? 1 : ((int'(cap_v) > Depth) ? Depth : int'(cap_v));
      hot_n = (eff + 2 > PoolSize) ? PoolSize : eff + 2;
      for (n = 0; n < PhaseItems; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          r.key = key_pool[$urandom_range(0, hot_n - 1)];
        end else if (sel < 85) begin
          r.key = key_pool[$urandom_range(0, PoolSize - 1)];
        end else if (sel < 93) begin
          r.key = $urandom;
        end else begin
          r.key = extreme_key[$urandom_range(0, 3)];
        end
        r.req_type = ($urandom_range(0, 99) < 45) ? ReqPut : ReqGet;
        r.value    = $urandom;
        issue_req(r, 1'b0, MissRsp);
      end
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    quiet_run  <= 1'b0;
    @(negedge clk_i);
    while (due_rsp_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("lfu_cache_lru_tiebreak regression: pass");
    end else begin
      $display("lfu_cache_lru_tiebreak regression: fail");
    end
    $finish;
  end

endmodule

// File: lfu_cache_lru_tiebreak.f
hw/rtl/lfuc_pkg.sv
hw/rtl/lfuc_ctrl.sv
hw/rtl/lfuc_dpath.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
tb/lfu_cache_lru_tiebreak_tb.sv
